>>> src/easing_curve_evaluator_top_macros.svh
// ----------------------------------------------------------------------------
// Easing curve evaluator assertion macros
// Shorthand for clocked assertions, reset-qualified on rst_ni.
// ----------------------------------------------------------------------------
`ifndef EASING_CURVE_EVALUATOR_TOP_MACROS_SVH
`define EASING_CURVE_EVALUATOR_TOP_MACROS_SVH

// Same-cycle implication
`define ECE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ECE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ece_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Easing curve evaluator package
// Widths, register codes, datapath commands and controller types.
// ----------------------------------------------------------------------------
package ece_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int IN_W       = 18;
  localparam int OUT_W      = 19;
  localparam int MODE_W     = 3;
  localparam int CX_W       = 17;
  localparam int CY_W       = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  // t is 0..one, s is -8..8 one
  localparam int T_W    = FRAC_BITS + 1;
  localparam int S_W    = FRAC_BITS + 5;
  localparam int SMAG_W = S_W - 1;
  localparam int COEF_W = 24;
  localparam int ACC_W  = 34;
  localparam int MAG_W  = ACC_W - 1;
  localparam int PROD_W = MAG_W + SMAG_W;
  localparam int DEN_W  = 32;
  localparam int NUM_W  = DEN_W + FRAC_BITS;
  localparam int DIFF_W = NUM_W + 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LINEAR   = 3'd0,
    MODE_EASE_IN  = 3'd1,
    MODE_EASE_OUT = 3'd2,
    MODE_IN_OUT   = 3'd3,
    MODE_BEZIER   = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE = 3'd0,
    CFG_C1X  = 3'd1,
    CFG_C1Y  = 3'd2,
    CFG_C2X  = 3'd3,
    CFG_C2Y  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SET,
    OP_MUL,
    OP_ACC,
    OP_ERR,
    OP_DIV,
    OP_STEP,
    OP_CLAMP,
    OP_RESULT
  } dp_op_e;

  typedef enum logic [3:0] {
    OPND_ZERO,
    OPND_S,
    OPND_AX,
    OPND_BX,
    OPND_CX,
    OPND_AX3,
    OPND_BX2,
    OPND_NEG_T,
    OPND_AY,
    OPND_BY,
    OPND_CY
  } opnd_e;

  typedef enum logic [1:0] {
    POLY_EASE,
    POLY_X,
    POLY_SLOPE,
    POLY_Y
  } poly_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET,
    ST_MUL,
    ST_ACC,
    ST_CHK_ERR,
    ST_CHK_SLOPE,
    ST_DIV,
    ST_STEP,
    ST_CLAMP,
    ST_RESULT
  } state_e;

  typedef struct packed {
    dp_op_e op;
    opnd_e  opnd;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  acc_zero;
    logic  div_done;
  } dp_stat_t;

endpackage

>>> src/easing_curve_evaluator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Easing curve evaluator top level
// Maps a progress value through a linear, cubic or Bezier easing curve.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with progress_i (signed Q16).
//   Output channel: out_valid_o / out_stall_i with eased_o (signed Q16).
//   A word moves when valid is high and stall is low at a rising edge.
//   Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (mode, then
//   control points). The user must write only while no word is in flight;
//   the block does not enforce it. One word is processed at a time;
//   in_stall_o is high while it runs. Linear mode goes straight to the
//   result; cubic ease modes first run the ease polynomial. Bezier mode
//   runs each Newton step as shared multiply-accumulate and error check
//   plus slope check, divider and update, then the clamp, the y polynomial
//   and the result: up to NEWTON_STEPS steps, fewer when a step ends early.
//   The divider (two quotient bits per cycle) sets the Bezier rate.
//   The finished word sits in an output register; the block keeps working
//   on the next word and holds it until the receiver drops stall.
//   Reset returns to idle, no output valid, config to its default curve.
// ----------------------------------------------------------------------------
module easing_curve_evaluator_top #(
  parameter int NEWTON_STEPS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [ece_pkg::IN_W-1:0]    progress_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [ece_pkg::OUT_W-1:0]   eased_o,
  input  logic                               cfg_we_i,
  input  logic [ece_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ece_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ece_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ece_ctrl #(
    .NEWTON_STEPS (NEWTON_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  ece_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .progress_i (progress_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .eased_o    (eased_o)
  );

endmodule

>>> src/ece_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Easing curve evaluator divider
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module ece_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ece_pkg::NUM_W-1:0] dividend_i,
  input  logic [ece_pkg::DEN_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [ece_pkg::NUM_W-1:0] quot_o
);
  import ece_pkg::*;

  localparam int ITER  = NUM_W / 2;
  localparam int CNT_W = $clog2(ITER);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [DEN_W:0] r1s, r1f, r2s, r2f;
  logic           ge1, ge2;

  // Two dependent subtract steps per cycle
  always_comb begin
    r1s   = {rem_q, num_q[NUM_W-1]};
    ge1   = r1s >= {1'b0, den_q};
    r1f   = ge1 ? r1s - {1'b0, den_q} : r1s;
    r2s   = {r1f[DEN_W-1:0], num_q[NUM_W-2]};
    ge2   = r2s >= {1'b0, den_q};
    r2f   = ge2 ? r2s - {1'b0, den_q} : r2s;
    rem_d = r2f[DEN_W-1:0];
    num_d = {num_q[NUM_W-3:0], ge1, ge2};
  end

  // Control: iteration count and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Payload: shift quotient bits in as dividend bits move out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

>>> src/ece_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Easing curve evaluator datapath
// Config registers, shared multiply-accumulate, Newton update and result.
// ----------------------------------------------------------------------------
module ece_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ece_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ece_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic signed [ece_pkg::IN_W-1:0]     progress_i,
  input  ece_pkg::dp_cmd_t                    cmd_i,
  output ece_pkg::dp_stat_t                   stat_o,
  output logic signed [ece_pkg::OUT_W-1:0]    eased_o
);
  import ece_pkg::*;

  localparam int R_W = ACC_W + 3;

  localparam logic signed [IN_W-1:0]   ONE_IN = IN_W'(64'd1 << FRAC_BITS);
  localparam logic [T_W-1:0]           ONE_T  = T_W'(64'd1 << FRAC_BITS);
  localparam logic [T_W-1:0]           HALF_T = T_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [S_W-1:0]    ONE_S  = S_W'(64'd1 << FRAC_BITS);
  localparam logic signed [COEF_W-1:0] ONE_C  = COEF_W'(64'd1 << FRAC_BITS);
  localparam logic signed [DIFF_W-1:0] EIGHT_D = DIFF_W'(64'd8 << FRAC_BITS);
  localparam logic signed [R_W-1:0]    ONE_R  = R_W'(64'd1 << FRAC_BITS);
  localparam logic signed [R_W-1:0]    MIN_R  = -(R_W'(64'd2 << FRAC_BITS));
  localparam logic signed [R_W-1:0]    MAX_R  = R_W'(64'd3 << FRAC_BITS);
  localparam logic [PROD_W-1:0]        RND_P  = PROD_W'(64'd1 << (FRAC_BITS - 1));

  // Configuration registers
  logic [MODE_W-1:0]      mode_q;
  logic [CX_W-1:0]        c1x_q, c2x_q;
  logic signed [CY_W-1:0] c1y_q, c2y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LINEAR;
      c1x_q  <= CX_W'(16384);
      c1y_q  <= CY_W'(6554);
      c2x_q  <= CX_W'(16384);
      c2y_q  <= CY_W'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
        CFG_C1X:  c1x_q  <= cfg_data_i[CX_W-1:0];
        CFG_C1Y:  c1y_q  <= cfg_data_i[CY_W-1:0];
        CFG_C2X:  c2x_q  <= cfg_data_i[CX_W-1:0];
        CFG_C2Y:  c2y_q  <= cfg_data_i[CY_W-1:0];
        default:  ;
      endcase
    end
  end

  // Undefined mode codes behave as linear
  mode_e eff_mode;
  always_comb begin
    case (mode_q)
      MODE_EASE_IN:  eff_mode = MODE_EASE_IN;
      MODE_EASE_OUT: eff_mode = MODE_EASE_OUT;
      MODE_IN_OUT:   eff_mode = MODE_IN_OUT;
      MODE_BEZIER:   eff_mode = MODE_BEZIER;
      default:       eff_mode = MODE_LINEAR;
    endcase
  end

  // Polynomial coefficients from the control points
  logic signed [COEF_W-1:0] c1x_e, c2x_e, c1y_e, c2y_e, dx, dy;
  logic signed [COEF_W-1:0] ax, bx, cx, ay, by, cy, ax3, bx2;

  always_comb begin
    c1x_e = $signed({{(COEF_W - CX_W){1'b0}}, c1x_q});
    c2x_e = $signed({{(COEF_W - CX_W){1'b0}}, c2x_q});
    c1y_e = $signed({{(COEF_W - CY_W){c1y_q[CY_W-1]}}, c1y_q});
    c2y_e = $signed({{(COEF_W - CY_W){c2y_q[CY_W-1]}}, c2y_q});
    cx    = (c1x_e <<< 1) + c1x_e;
    dx    = c2x_e - c1x_e;
    bx    = (dx <<< 1) + dx - cx;
    ax    = ONE_C - cx - bx;
    cy    = (c1y_e <<< 1) + c1y_e;
    dy    = c2y_e - c1y_e;
    by    = (dy <<< 1) + dy - cy;
    ay    = ONE_C - cy - by;
    ax3   = (ax <<< 1) + ax;
    bx2   = bx <<< 1;
  end

  // Working registers
  logic [T_W-1:0]           t_q;
  logic signed [S_W-1:0]    s_q;
  logic signed [ACC_W-1:0]  acc_q, err_q;
  logic [PROD_W-1:0]        prod_q;
  logic                     neg_q, qneg_q;
  logic signed [OUT_W-1:0]  eased_q;

  // Clamp the incoming progress and pick the cubed variable
  logic [T_W-1:0]        t_in;
  logic signed [S_W-1:0] t_s, s_load;

  always_comb begin
    if (progress_i < 0) begin
      t_in = '0;
    end else if (progress_i > ONE_IN) begin
      t_in = ONE_T;
    end else begin
      t_in = progress_i[T_W-1:0];
    end
    t_s = $signed({{(S_W - T_W){1'b0}}, t_in});
    case (eff_mode)
      MODE_EASE_OUT: s_load = ONE_S - t_s;
      MODE_IN_OUT:   s_load = (t_in < HALF_T) ? t_s : (ONE_S <<< 1) - (t_s <<< 1);
      default:       s_load = t_s;
    endcase
  end

  // Operand select
  function automatic logic signed [ACC_W-1:0] ext_c(input logic signed [COEF_W-1:0] v);
    return {{(ACC_W - COEF_W){v[COEF_W-1]}}, v};
  endfunction

  logic signed [ACC_W-1:0] opnd;
  always_comb begin
    case (cmd_i.opnd)
      OPND_S:     opnd = {{(ACC_W - S_W){s_q[S_W-1]}}, s_q};
      OPND_AX:    opnd = ext_c(ax);
      OPND_BX:    opnd = ext_c(bx);
      OPND_CX:    opnd = ext_c(cx);
      OPND_AX3:   opnd = ext_c(ax3);
      OPND_BX2:   opnd = ext_c(bx2);
      OPND_NEG_T: opnd = -$signed({{(ACC_W - T_W){1'b0}}, t_q});
      OPND_AY:    opnd = ext_c(ay);
      OPND_BY:    opnd = ext_c(by);
      OPND_CY:    opnd = ext_c(cy);
      default:    opnd = '0;
    endcase
  end

  // Magnitudes for the multiplier and divider
  logic signed [ACC_W-1:0] acc_neg, err_neg;
  logic signed [S_W-1:0]   s_neg;
  logic [MAG_W-1:0]        acc_mag, err_mag;
  logic [SMAG_W-1:0]       s_mag;

  always_comb begin
    acc_neg = -acc_q;
    err_neg = -err_q;
    s_neg   = -s_q;
    acc_mag = acc_q[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_q[MAG_W-1:0];
    err_mag = err_q[ACC_W-1] ? err_neg[MAG_W-1:0] : err_q[MAG_W-1:0];
    s_mag   = s_q[S_W-1] ? s_neg[SMAG_W-1:0] : s_q[SMAG_W-1:0];
  end

  // Round the product magnitude half away from zero, then add the operand
  logic [PROD_W-1:0]       rnd;
  logic signed [ACC_W-1:0] prod_r, acc_sum;

  always_comb begin
    rnd     = (prod_q + RND_P) >> FRAC_BITS;
    prod_r  = neg_q ? -$signed(rnd[ACC_W-1:0]) : $signed(rnd[ACC_W-1:0]);
    acc_sum = opnd + prod_r;
  end

  // Divider for the Newton step
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num, quot;
  logic [DEN_W-1:0]  div_den;

  assign div_start = (cmd_i.op == OP_DIV);
  assign div_num   = {err_mag[NUM_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
  assign div_den   = acc_mag[DEN_W-1:0];

  ece_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Newton update with runaway limit, and final clamp of s
  logic signed [DIFF_W-1:0] q_e, step_v, s_ext, s_diff;
  logic signed [S_W-1:0]    s_step, s_clamp;

  always_comb begin
    q_e    = $signed({2'b00, quot});
    step_v = qneg_q ? -q_e : q_e;
    s_ext  = {{(DIFF_W - S_W){s_q[S_W-1]}}, s_q};
    s_diff = s_ext - step_v;
    if (s_diff > EIGHT_D) begin
      s_step = S_W'(EIGHT_D);
    end else if (s_diff < -EIGHT_D) begin
      s_step = S_W'(-EIGHT_D);
    end else begin
      s_step = s_diff[S_W-1:0];
    end
    if (s_q < 0) begin
      s_clamp = '0;
    end else if (s_q > ONE_S) begin
      s_clamp = ONE_S;
    end else begin
      s_clamp = s_q;
    end
  end

  // Final value per mode, saturated to -2..3 (inside the output range)
  logic signed [R_W-1:0] acc_r, t_r, r_raw, r_sat;

  always_comb begin
    acc_r = {{(R_W - ACC_W){acc_q[ACC_W-1]}}, acc_q};
    t_r   = $signed({{(R_W - T_W){1'b0}}, t_q});
    case (eff_mode)
      MODE_EASE_IN:  r_raw = acc_r;
      MODE_EASE_OUT: r_raw = ONE_R - acc_r;
      MODE_IN_OUT:   r_raw = (t_q < HALF_T) ? (acc_r <<< 2) : ONE_R - ((acc_r + 1) >>> 1);
      MODE_BEZIER:   r_raw = acc_r;
      default:       r_raw = t_r;
    endcase
    if (r_raw < MIN_R) begin
      r_sat = MIN_R;
    end else if (r_raw > MAX_R) begin
      r_sat = MAX_R;
    end else begin
      r_sat = r_raw;
    end
  end

  // Execute the command
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        t_q <= t_in;
        s_q <= s_load;
      end
      OP_SET:  acc_q <= opnd;
      OP_MUL: begin
        prod_q <= acc_mag * s_mag;
        neg_q  <= acc_q[ACC_W-1] ^ s_q[S_W-1];
      end
      OP_ACC:    acc_q <= acc_sum;
      OP_ERR:    err_q <= acc_q;
      OP_DIV:    qneg_q <= err_q[ACC_W-1] ^ acc_q[ACC_W-1];
      OP_STEP:   s_q <= s_step;
      OP_CLAMP:  s_q <= s_clamp;
      OP_RESULT: eased_q <= r_sat[OUT_W-1:0];
      default:   ;
    endcase
  end

  assign stat_o.mode     = eff_mode;
  assign stat_o.acc_zero = (acc_q == '0);
  assign stat_o.div_done = div_done;
  assign eased_o         = eased_q;

endmodule

>>> src/ece_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Easing curve evaluator controller
// Sequences the datapath through the curve polynomials and Newton steps.
// ----------------------------------------------------------------------------
`include "easing_curve_evaluator_top_macros.svh"

module ece_ctrl #(
  parameter int NEWTON_STEPS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ece_pkg::dp_cmd_t  cmd_o,
  input  ece_pkg::dp_stat_t stat_i
);
  import ece_pkg::*;

  localparam int CNT_W = $clog2(NEWTON_STEPS + 1);

  state_e           state_q, state_d;
  poly_e            poly_q, poly_d;
  logic [1:0]       term_q, term_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  logic       out_free;
  logic [1:0] last_term;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_term = (poly_q == POLY_X || poly_q == POLY_Y) ? 2'd2 : 2'd1;

  // Next state
  always_comb begin
    state_d     = state_q;
    poly_d      = poly_q;
    term_d      = term_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          term_d = '0;
          cnt_d  = '0;
          case (stat_i.mode)
            MODE_LINEAR: state_d = ST_RESULT;
            MODE_BEZIER: begin
              state_d = ST_SET;
              poly_d  = POLY_X;
            end
            default: begin
              state_d = ST_SET;
              poly_d  = POLY_EASE;
            end
          endcase
        end
      end
      ST_SET: state_d = ST_MUL;
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        if (term_q == last_term) begin
          term_d = '0;
          case (poly_q)
            POLY_X:     state_d = ST_CHK_ERR;
            POLY_SLOPE: state_d = ST_CHK_SLOPE;
            default:    state_d = ST_RESULT;
          endcase
        end else begin
          term_d  = term_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_CHK_ERR: begin
        if (stat_i.acc_zero) begin
          state_d = ST_CLAMP;
        end else begin
          state_d = ST_SET;
          poly_d  = POLY_SLOPE;
        end
      end
      ST_CHK_SLOPE: state_d = stat_i.acc_zero ? ST_CLAMP : ST_DIV;
      ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (cnt_q == CNT_W'(NEWTON_STEPS - 1)) begin
          state_d = ST_CLAMP;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_SET;
          poly_d  = POLY_X;
        end
      end
      ST_CLAMP: begin
        state_d = ST_SET;
        poly_d  = POLY_Y;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o.op   = OP_NOP;
    cmd_o.opnd = OPND_ZERO;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
        end
      end
      ST_SET: begin
        cmd_o.op = OP_SET;
        case (poly_q)
          POLY_X:     cmd_o.opnd = OPND_AX;
          POLY_SLOPE: cmd_o.opnd = OPND_AX3;
          POLY_Y:     cmd_o.opnd = OPND_AY;
          default:    cmd_o.opnd = OPND_S;
        endcase
      end
      ST_MUL: cmd_o.op = OP_MUL;
      ST_ACC: begin
        cmd_o.op = OP_ACC;
        case (poly_q)
          POLY_X: begin
            if (term_q == 2'd0) begin
              cmd_o.opnd = OPND_BX;
            end else if (term_q == 2'd1) begin
              cmd_o.opnd = OPND_CX;
            end else begin
              cmd_o.opnd = OPND_NEG_T;
            end
          end
          POLY_SLOPE: cmd_o.opnd = (term_q == 2'd0) ? OPND_BX2 : OPND_CX;
          POLY_Y: begin
            if (term_q == 2'd0) begin
              cmd_o.opnd = OPND_BY;
            end else if (term_q == 2'd1) begin
              cmd_o.opnd = OPND_CY;
            end else begin
              cmd_o.opnd = OPND_ZERO;
            end
          end
          default: cmd_o.opnd = OPND_ZERO;
        endcase
      end
      ST_CHK_ERR: begin
        if (!stat_i.acc_zero) begin
          cmd_o.op = OP_ERR;
        end
      end
      ST_CHK_SLOPE: begin
        if (!stat_i.acc_zero) begin
          cmd_o.op = OP_DIV;
        end
      end
      ST_STEP:  cmd_o.op = OP_STEP;
      ST_CLAMP: cmd_o.op = OP_CLAMP;
      ST_RESULT: begin
        if (out_free) begin
          cmd_o.op = OP_RESULT;
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      poly_q      <= POLY_EASE;
      term_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      poly_q      <= poly_d;
      term_q      <= term_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `ECE_ASSERT_NXT(a_accept_busy, in_valid_i && !in_stall_o, state_q != ST_IDLE, "accepted word did not start work")
  `ECE_ASSERT_NXT(a_result_valid, state_q == ST_RESULT && out_free, out_valid_q, "result word not presented")
  `ECE_ASSERT_IMP(a_step_bound, state_q != ST_IDLE, cnt_q < CNT_W'(NEWTON_STEPS), "Newton count overran")

endmodule
